// ===== sv/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 compression core.
// Used by sha256_ctrl, sha256_dp and sha256_compression_core.
package sha256_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned WindowDepth = 16;
    localparam int unsigned NumRounds   = 64;
    localparam int unsigned HashWords   = 8;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_FINAL
    } t_state;

    // Controller to datapath command bundle
    typedef struct packed {
        logic       shift_in;   // accepted word enters the schedule window
        logic       load_iv;    // chaining value takes the initial hash
        logic       load_work;  // a..h take the chaining value
        logic       round_en;   // run one compression round
        logic [5:0] round_idx;  // round number for the constant lookup
        logic       final_add;  // fold a..h into the chaining value
        logic       emit;       // capture the new chaining value as digest
    } t_dp_cmd;

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            3'd7:    v = 32'h5be0cd19;
            default: v = 32'h6a09e667;
        endcase
        return v;
    endfunction

    function automatic t_word round_k(input logic [5:0] idx);
        t_word v;
        case (idx)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
            default: v = 32'h428a2f98;
        endcase
        return v;
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== sv/sha256_compression_core.sv =====
// SHA-256 compression core, top level: controller plus datapath.
// Depends on sha256_pkg, sha256_ctrl and sha256_dp.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one padded 32-bit message word per
//    transaction, big-endian. Sixteen transactions make one block. The
//    first-of-message flag, seen on a block's first word, reloads the standard
//    initial hash; the last-of-message flag on any word of a block requests
//    the digest after that block.
//  - Output channel (o_out_valid / i_out_stall): one 256-bit digest transaction,
//    split into four 64-bit fields, after each block that ends a message.
//  - Timing: words are taken one per cycle while loading. The 16th word starts
//    the compression: 64 rounds, one round per cycle on the single round
//    unit, then a fold of a..h into the chaining value. Input stalls through
//    the rounds and the fold. Digest is captured with the fold and is valid in
//    the cycle after it.
//  - The digest sits in an output register; the core keeps loading the next
//    block while it waits. If a second digest is ready before the first is
//    taken, the core holds in the fold step until the output drains.
//  - Reset (synchronous, active low) clears the word count and pending flags
//    and sets the chaining value to the initial hash.
module sha256_compression_core
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_msg_word,
    input  logic        i_first_of_message,
    input  logic        i_last_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_digest_bits_255_192,
    output logic [63:0] o_digest_bits_191_128,
    output logic [63:0] o_digest_bits_127_64,
    output logic [63:0] o_digest_bits_63_0
);

    t_dp_cmd cmd;

    sha256_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_first_of_message (i_first_of_message),
        .i_last_of_message  (i_last_of_message),
        .o_in_stall         (o_in_stall),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_cmd              (cmd)
    );

    sha256_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_msg_word            (i_msg_word),
        .o_digest_bits_255_192 (o_digest_bits_255_192),
        .o_digest_bits_191_128 (o_digest_bits_191_128),
        .o_digest_bits_127_64  (o_digest_bits_127_64),
        .o_digest_bits_63_0    (o_digest_bits_63_0)
    );

    // A word enters the window exactly when an input transaction completes
    a_shift_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.shift_in == (i_in_valid && !o_in_stall))
        else $error("schedule shift does not match input transaction");

    // Starting a compression must close the input side
    a_stall_in_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_work |=> o_in_stall)
        else $error("input open during compression");

    // A new digest never overwrites one that is held by a stalled receiver
    a_no_digest_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !(o_out_valid && i_out_stall))
        else $error("digest overwritten while output stalled");

    // Digest capture always comes with the chaining-value fold, and shows up next
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> cmd.final_add ##1 o_out_valid)
        else $error("digest emit without fold or valid");

endmodule

// ===== sv/sha256_ctrl.sv =====
// Sequencer for the SHA-256 compression core: word count, round count,
// digest-pending flag and output valid. Depends on sha256_pkg.
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_first_of_message,
    input  logic    i_last_of_message,
    output logic    o_in_stall,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_word_pos, n_word_pos;
    logic [5:0] r_round, n_round;
    logic       r_end_pending, n_end_pending;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_LOAD;
            r_word_pos    <= 4'd0;
            r_round       <= 6'd0;
            r_end_pending <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_word_pos    <= n_word_pos;
            r_round       <= n_round;
            r_end_pending <= n_end_pending;
            r_out_valid   <= n_out_valid;
        end
    end

    assign accept   = i_in_valid && (r_state == ST_LOAD);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        n_word_pos    = r_word_pos;
        n_round       = r_round;
        n_end_pending = r_end_pending;
        n_out_valid   = r_out_valid && i_out_stall;
        o_cmd         = '0;
        o_cmd.round_idx = r_round;

        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    o_cmd.shift_in = 1'b1;
                    o_cmd.load_iv  = (r_word_pos == 4'd0) && i_first_of_message;
                    n_end_pending  = r_end_pending || i_last_of_message;
                    n_word_pos     = r_word_pos + 4'd1;
                    if (r_word_pos == 4'd15) begin
                        o_cmd.load_work = 1'b1;
                        n_round         = 6'd0;
                        n_state         = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_round        = r_round + 6'd1;
                if (r_round == 6'(NumRounds - 1)) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (!r_end_pending) begin
                    o_cmd.final_add = 1'b1;
                    n_state         = ST_LOAD;
                end else if (out_free) begin
                    // digest slot is free or drains this cycle
                    o_cmd.final_add = 1'b1;
                    o_cmd.emit      = 1'b1;
                    n_out_valid     = 1'b1;
                    n_end_pending   = 1'b0;
                    n_state         = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/sha256_dp.sv =====
// Datapath of the SHA-256 compression core: schedule window shift line,
// a..h round registers, chaining value and digest output register. Uses sha256_pkg.
module sha256_dp
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [31:0] i_msg_word,
    output logic [63:0] o_digest_bits_255_192,
    output logic [63:0] o_digest_bits_191_128,
    output logic [63:0] o_digest_bits_127_64,
    output logic [63:0] o_digest_bits_63_0
);

    t_word r_win [WindowDepth];
    t_word r_wv  [HashWords];
    t_word r_cv  [HashWords];
    t_word cv_sum [HashWords];
    logic [63:0] r_dig [4];

    t_word sched_next;
    t_word t1, t2;

    // sched[t] sits in r_win[0]; for the new word sched[t+16] the taps t+1, t+9, t+14 are 1, 9, 14
    assign sched_next = r_win[0] + small_sigma0(r_win[1]) + r_win[9]
                      + small_sigma1(r_win[14]);

    assign t1 = r_wv[7] + big_sigma1(r_wv[4])
              + ((r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]))
              + round_k(i_cmd.round_idx) + r_win[0];
    assign t2 = big_sigma0(r_wv[0])
              + ((r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]));

    always_comb begin
        for (int i = 0; i < HashWords; i++) begin
            cv_sum[i] = r_cv[i] + r_wv[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_in || i_cmd.round_en) begin
            for (int i = 0; i < WindowDepth - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WindowDepth-1] <= i_cmd.shift_in ? i_msg_word : sched_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            for (int i = 0; i < HashWords; i++) begin
                r_wv[i] <= r_cv[i];
            end
        end else if (i_cmd.round_en) begin
            r_wv[7] <= r_wv[6];
            r_wv[6] <= r_wv[5];
            r_wv[5] <= r_wv[4];
            r_wv[4] <= r_wv[3] + t1;
            r_wv[3] <= r_wv[2];
            r_wv[2] <= r_wv[1];
            r_wv[1] <= r_wv[0];
            r_wv[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HashWords; i++) begin
                r_cv[i] <= init_hash(3'(i));
            end
        end else if (i_cmd.load_iv) begin
            for (int i = 0; i < HashWords; i++) begin
                r_cv[i] <= init_hash(3'(i));
            end
        end else if (i_cmd.final_add) begin
            for (int i = 0; i < HashWords; i++) begin
                r_cv[i] <= cv_sum[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            for (int k = 0; k < 4; k++) begin
                r_dig[k] <= {cv_sum[2*k], cv_sum[2*k+1]};
            end
        end
    end

    assign o_digest_bits_255_192 = r_dig[0];
    assign o_digest_bits_191_128 = r_dig[1];
    assign o_digest_bits_127_64  = r_dig[2];
    assign o_digest_bits_63_0    = r_dig[3];

endmodule
